>>> sv/sdt_pkg.sv
// ----------------------------------------------------------------------------
// sdt_pkg
// shared types, field widths and codes of the sorted date table
// ----------------------------------------------------------------------------
package sdt_pkg;

  localparam int CAPACITY_DEFAULT = 32;

  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int DATE_W   = YEAR_W + MONTH_W + DAY_W;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;

  typedef logic [DATE_W-1:0] date_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_RANGE  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_FOUND    = 3'd2,
    ST_ABSENT   = 3'd3,
    ST_LISTED   = 3'd4,
    ST_NONE     = 3'd5,
    ST_CLEARED  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_TOP,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,
    WR_KEY_UP,
    WR_KEY_BOT
  } wr_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_INC
  } cnt_op_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_CODE,
    EMIT_PEND_MID,
    EMIT_PEND_LAST
  } emit_t;

  // controller to datapath
  typedef struct packed {
    logic    load_key;
    ptr_op_t ptr_op;
    wr_sel_t wr_sel;
    cnt_op_t cnt_op;
    emit_t   emit;
    status_t code;
    logic    pend_clear;
    logic    pend_load;
  } sdt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic ptr_zero;
    logic ptr_at_end;
    logic gt;
    logic eq;
    logic in_range;
    logic pend_valid;
    logic out_free;
  } sdt_sts_t;

endpackage

>>> sv/sdt_datapath.sv
// ----------------------------------------------------------------------------
// sdt_datapath
// date memory, scan pointer, entry count, pending date and result register
// ----------------------------------------------------------------------------
module sdt_datapath #(
  parameter int CAPACITY = sdt_pkg::CAPACITY_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [sdt_pkg::DAY_W-1:0]    day,
  input  logic [sdt_pkg::MONTH_W-1:0]  month,
  input  logic [sdt_pkg::YEAR_W-1:0]   year,
  input  logic [sdt_pkg::DAY_W-1:0]    upper_day,
  input  logic [sdt_pkg::MONTH_W-1:0]  upper_month,
  input  logic [sdt_pkg::YEAR_W-1:0]   upper_year,
  input  logic                         out_ready,
  input  sdt_pkg::sdt_cmd_t            cmd,
  output sdt_pkg::sdt_sts_t            sts,
  output logic                         out_valid,
  output logic [sdt_pkg::STATUS_W-1:0] status,
  output logic [sdt_pkg::DAY_W-1:0]    out_day,
  output logic [sdt_pkg::MONTH_W-1:0]  out_month,
  output logic [sdt_pkg::YEAR_W-1:0]   out_year,
  output logic                         last
);
  import sdt_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  date_t         mem [CAPACITY];
  date_t         rdata;
  date_t         key;
  date_t         hi;
  date_t         pend_date;
  logic          pend_valid;
  logic [AW-1:0] ptr;
  logic [AW-1:0] ptr_next;
  logic [CW-1:0] count;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  date_t         wr_data;
  date_t         out_date;

  // operands of the current transaction
  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key <= {year, month, day};
      hi  <= {upper_year, upper_month, upper_day};
    end
  end

  always_comb begin
    case (cmd.ptr_op)
      PTR_ZERO: ptr_next = '0;
      PTR_TOP:  ptr_next = AW'(count - CW'(1));
      PTR_INC:  ptr_next = ptr + AW'(1);
      PTR_DEC:  ptr_next = ptr - AW'(1);
      default:  ptr_next = ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = ptr + AW'(1);
    wr_data = key;
    case (cmd.wr_sel)
      WR_SHIFT:   wr_data = rdata;
      WR_KEY_UP:  wr_data = key;
      WR_KEY_BOT: wr_addr = '0;
      default:    wr_en   = 1'b0;
    endcase
  end

  // one write and one registered read a cycle; rdata follows ptr
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[ptr_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.cnt_op)
        CNT_CLEAR: count <= '0;
        CNT_INC:   count <= count + CW'(1);
        default:   count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.pend_clear) begin
      pend_valid <= 1'b0;
    end else if (cmd.pend_load) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_load) begin
      pend_date <= rdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      EMIT_CODE: begin
        status   <= cmd.code;
        out_date <= '0;
        last     <= 1'b1;
      end
      EMIT_PEND_MID: begin
        status   <= ST_LISTED;
        out_date <= pend_date;
        last     <= 1'b0;
      end
      EMIT_PEND_LAST: begin
        status   <= ST_LISTED;
        out_date <= pend_date;
        last     <= 1'b1;
      end
      default: begin
        status   <= status;
        out_date <= out_date;
        last     <= last;
      end
    endcase
  end

  assign out_day   = out_date[DAY_W-1:0];
  assign out_month = out_date[DAY_W +: MONTH_W];
  assign out_year  = out_date[DAY_W+MONTH_W +: YEAR_W];

  always_comb begin
    sts.cnt_zero   = (count == '0);
    sts.cnt_full   = (count == CW'(CAPACITY));
    sts.ptr_zero   = (ptr == '0);
    sts.ptr_at_end = ((CW'(ptr) + CW'(1)) == count);
    sts.gt         = (rdata > key);
    sts.eq         = (rdata == key);
    sts.in_range   = (key < rdata) && (rdata < hi);
    sts.pend_valid = pend_valid;
    sts.out_free   = !out_valid || out_ready;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit != EMIT_NONE) |-> sts.out_free)
    else $error("result register overwritten while stalled");

  a_pend_emit: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit == EMIT_PEND_MID || cmd.emit == EMIT_PEND_LAST) |-> pend_valid)
    else $error("listed date sent without a pending date");
`endif

endmodule

>>> sv/sdt_controller.sv
// ----------------------------------------------------------------------------
// sdt_controller
// sequencer for insert, find, range listing and clear
// ----------------------------------------------------------------------------
module sdt_controller (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [sdt_pkg::OP_W-1:0] op,
  input  sdt_pkg::sdt_sts_t        sts,
  output sdt_pkg::sdt_cmd_t        cmd
);
  import sdt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_INS_SCAN = 6'b000010,
    S_INS_BOT  = 6'b000100,
    S_FIND     = 6'b001000,
    S_RNG_SCAN = 6'b010000,
    S_RESP     = 6'b100000
  } state_t;

  state_t  state;
  state_t  state_next;
  status_t resp;
  status_t resp_next;
  logic    rng_end;
  logic    rng_end_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rng_end <= 1'b0;
    end else begin
      state   <= state_next;
      rng_end <= rng_end_next;
    end
  end

  always_ff @(posedge clk) begin
    resp <= resp_next;
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    resp_next      = resp;
    rng_end_next   = rng_end;
    cmd            = '0;
    cmd.code       = resp;
    unique case (state)
      S_IDLE: begin
        rng_end_next = 1'b0;
        if (in_valid) begin
          cmd.load_key = 1'b1;
          unique case (op_t'(op))
            OP_INSERT: begin
              if (sts.cnt_full) begin
                resp_next  = ST_FULL;
                state_next = S_RESP;
              end else if (sts.cnt_zero) begin
                state_next = S_INS_BOT;
              end else begin
                cmd.ptr_op = PTR_TOP;
                state_next = S_INS_SCAN;
              end
            end
            OP_FIND: begin
              if (sts.cnt_zero) begin
                resp_next  = ST_ABSENT;
                state_next = S_RESP;
              end else begin
                cmd.ptr_op = PTR_ZERO;
                state_next = S_FIND;
              end
            end
            OP_RANGE: begin
              cmd.pend_clear = 1'b1;
              if (sts.cnt_zero) begin
                resp_next  = ST_NONE;
                state_next = S_RESP;
              end else begin
                cmd.ptr_op = PTR_ZERO;
                state_next = S_RNG_SCAN;
              end
            end
            OP_CLEAR: begin
              cmd.cnt_op = CNT_CLEAR;
              resp_next  = ST_CLEARED;
              state_next = S_RESP;
            end
          endcase
        end
      end
      S_INS_SCAN: begin
        if (sts.gt) begin
          cmd.wr_sel = WR_SHIFT;
          if (sts.ptr_zero) begin
            state_next = S_INS_BOT;
          end else begin
            cmd.ptr_op = PTR_DEC;
          end
        end else begin
          cmd.wr_sel = WR_KEY_UP;
          cmd.cnt_op = CNT_INC;
          resp_next  = ST_INSERTED;
          state_next = S_RESP;
        end
      end
      S_INS_BOT: begin
        cmd.wr_sel = WR_KEY_BOT;
        cmd.cnt_op = CNT_INC;
        resp_next  = ST_INSERTED;
        state_next = S_RESP;
      end
      S_FIND: begin
        if (sts.eq) begin
          resp_next  = ST_FOUND;
          state_next = S_RESP;
        end else if (sts.ptr_at_end) begin
          resp_next  = ST_ABSENT;
          state_next = S_RESP;
        end else begin
          cmd.ptr_op = PTR_INC;
        end
      end
      S_RNG_SCAN: begin
        // a match flushes the previous one, so wait if the result is stalled
        if (!(sts.in_range && sts.pend_valid && !sts.out_free)) begin
          if (sts.in_range) begin
            cmd.pend_load = 1'b1;
            if (sts.pend_valid) begin
              cmd.emit = EMIT_PEND_MID;
            end
          end
          if (sts.ptr_at_end) begin
            rng_end_next = 1'b1;
            resp_next    = ST_NONE;
            state_next   = S_RESP;
          end else begin
            cmd.ptr_op = PTR_INC;
          end
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          if (rng_end && sts.pend_valid) begin
            cmd.emit = EMIT_PEND_LAST;
          end else begin
            cmd.emit = EMIT_CODE;
          end
          state_next = S_IDLE;
        end
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("transaction accepted while previous one in progress");

  a_single_final: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit == EMIT_CODE || cmd.emit == EMIT_PEND_LAST) |=> (state == S_IDLE))
    else $error("final result sent without returning to idle");
`endif

endmodule

>>> sv/sorted_date_table.sv
// ----------------------------------------------------------------------------
// sorted_date_table
// table of calendar dates kept in ascending order with insert, find,
// range listing and clear
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_ready with op and the date fields; one
//   transaction is taken only while the block is idle
//   output channel: out_valid/out_ready with status, out_day, out_month,
//   out_year and last; last marks the final result of a transaction
//   insert, find and clear give one result; range gives one result per
//   date strictly between the bounds, or one 'none' result
// sequence, from the accepted transaction to its result
//   clear, full insert, find or range on an empty table: sent straight
//   to the result; insert: entries moved up one per cycle from the top
//   until the new date fits; find: entries read from the bottom up to
//   a match or the top; range: every entry read from the bottom, each
//   match held pending until the next so the last can be flagged
//   the next transaction is taken once the final result is loaded
// reset
//   the entry count clears, the output empties, the memory is not cleared
// stalls
//   a held result waits in the output register; the final result and any
//   further range match wait until that register frees
// ----------------------------------------------------------------------------
module sorted_date_table #(
  parameter int CAPACITY = sdt_pkg::CAPACITY_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sdt_pkg::OP_W-1:0]     op,
  input  logic [sdt_pkg::DAY_W-1:0]    day,
  input  logic [sdt_pkg::MONTH_W-1:0]  month,
  input  logic [sdt_pkg::YEAR_W-1:0]   year,
  input  logic [sdt_pkg::DAY_W-1:0]    upper_day,
  input  logic [sdt_pkg::MONTH_W-1:0]  upper_month,
  input  logic [sdt_pkg::YEAR_W-1:0]   upper_year,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sdt_pkg::STATUS_W-1:0] status,
  output logic [sdt_pkg::DAY_W-1:0]    out_day,
  output logic [sdt_pkg::MONTH_W-1:0]  out_month,
  output logic [sdt_pkg::YEAR_W-1:0]   out_year,
  output logic                         last
);
  import sdt_pkg::*;

  // command and status between sequencer and datapath
  sdt_cmd_t cmd;
  sdt_sts_t sts;

  // sequencer: decodes the op, steps one entry per cycle unless stalled
  sdt_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: date memory, comparators, count and result register
  sdt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .day         (day),
    .month       (month),
    .year        (year),
    .upper_day   (upper_day),
    .upper_month (upper_month),
    .upper_year  (upper_year),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .status      (status),
    .out_day     (out_day),
    .out_month   (out_month),
    .out_year    (out_year),
    .last        (last)
  );

endmodule
